[sv/cgs_pkg.sv]
package cgs_pkg;

   // One point as stored: x in the low half, y in the high half.
   typedef struct packed {
      logic signed [31:0] y;
      logic signed [31:0] x;
   } pt_type;

   // Sign of a cross product, as returned by the sign unit.
   typedef struct packed {
      logic done;
      logic neg;
      logic zero;
   } sign_type;

   typedef enum logic [4:0] {
      S_LOAD,
      S_PIV_RD,
      S_PIV_CMP,
      S_SWP_RD,
      S_SWP_W0,
      S_SWP_WB,
      S_SRT_KEY,
      S_SRT_KWT,
      S_SRT_RD,
      S_SRT_CMP,
      S_SRT_WAIT,
      S_SRT_PUT,
      S_SCN_RD,
      S_SCN_GET,
      S_SCN_CHK,
      S_SCN_WAIT,
      S_SCN_H0,
      S_SCN_PUSH,
      S_OUT_RD,
      S_OUT_GET,
      S_OUT_HOLD
   } state_type;

   // Lexicographic order on 33-bit offsets: x first, then y.
   function automatic logic lex_less(input logic signed [32:0] ax,
                                     input logic signed [32:0] ay,
                                     input logic signed [32:0] bx,
                                     input logic signed [32:0] by);
      lex_less = (ax < bx) || ((ax == bx) && (ay < by));
   endfunction

endpackage

[sv/cgs_ram.sv]
module cgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/cgs_cross.sv]
module cgs_cross (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [32:0]   ux,
   input  logic signed [32:0]   uy,
   input  logic signed [32:0]   wx,
   input  logic signed [32:0]   wy,
   output cgs_pkg::sign_type    result
);
   import cgs_pkg::*;

   logic signed [32:0] ux_ff, uy_ff, wx_ff, wy_ff;
   logic               v1_ff, v2_ff, done_ff;
   logic signed [65:0] p_ff, q_ff;
   logic signed [66:0] diff;
   logic               neg_ff, zero_ff;

   // Valid bits travel alongside the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   assign diff = {p_ff[65], p_ff} - {q_ff[65], q_ff};

   // Operand register, two products, then the sign of their difference.
   always_ff @(posedge clock) begin
      ux_ff   <= ux;
      uy_ff   <= uy;
      wx_ff   <= wx;
      wy_ff   <= wy;
      p_ff    <= ux_ff * wy_ff;
      q_ff    <= uy_ff * wx_ff;
      neg_ff  <= diff[66];
      zero_ff <= (diff == '0);
   end

   assign result.done = done_ff;
   assign result.neg  = neg_ff;
   assign result.zero = zero_ff;

endmodule

[sv/convex_hull_graham_scan.sv]
// Channel  Direction  Handshake             Contents
// req      in         req_tvalid/tready     point x, y; tlast marks the final point
// rsp      out        rsp_tvalid/tready     hull vertex x, y; tlast marks the final vertex
// csr      in         csr_valid/ready       keep_collinear
//
// Points load at one per cycle. After the final point the pivot search scans the
// stored points and the swap moves the pivot to address 0. The insertion sort
// makes up to n*n/2 comparisons of a key with earlier points, each in the
// three-stage sign unit. The scan runs a convexity check per point in the sign
// unit and checks again after a pop; each vertex is read from the stack and
// held until rsp takes it. No point is taken while a set is computed or its hull
// is sent. Reset is synchronous; both memories need no clearing.
module convex_hull_graham_scan #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] point_x, [63:32] point_y
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] vertex_x, [63:32] vertex_y
   output logic        rsp_tlast,   // last_vertex
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // keep_collinear
);
   import cgs_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   state_type state_ff, state_in;

   logic          keep_csr_ff, keep_ff;
   logic [CW-1:0] cnt_ff, n_ff, i_ff, j_ff, sz_ff, best_ff;
   pt_type        best_pt_ff, piv_ff, tmp_ff, key_ff, q_ff, p_ff, h0_ff, h1_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   pt_type        rsp_data_ff;

   logic          st_we, hs_we;
   logic [AW-1:0] st_wa, st_ra, hs_wa, hs_ra;
   pt_type        st_wd, hs_wd, st_rd, hs_rd;

   logic               x_start;
   logic signed [32:0] x_ux, x_uy, x_wx, x_wy;
   sign_type           sgn;

   logic          req_acc, is_less, do_pop, tie_less;
   logic [CW-1:0] i_nx, j_dec, sz_dec, sz_m3;
   logic signed [32:0] kx, ky, qx, qy;

   assign req_acc = req_tvalid && req_tready;
   assign i_nx    = i_ff + CW'(1);
   assign j_dec   = j_ff - CW'(1);
   assign sz_dec  = sz_ff - CW'(1);
   assign sz_m3   = sz_ff - CW'(3);

   cgs_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );

   cgs_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_stack (
      .clock(clock), .wr_en(hs_we), .wr_addr(hs_wa), .wr_data(hs_wd),
      .rd_addr(hs_ra), .rd_data(hs_rd)
   );

   cgs_cross u_cross (
      .clock(clock), .reset(reset), .start(x_start),
      .ux(x_ux), .uy(x_uy), .wx(x_wx), .wy(x_wy), .result(sgn)
   );

   // Offsets from the pivot for the angle tie break.
   assign kx = {key_ff.x[31], key_ff.x} - {piv_ff.x[31], piv_ff.x};
   assign ky = {key_ff.y[31], key_ff.y} - {piv_ff.y[31], piv_ff.y};
   assign qx = {q_ff.x[31], q_ff.x} - {piv_ff.x[31], piv_ff.x};
   assign qy = {q_ff.y[31], q_ff.y} - {piv_ff.y[31], piv_ff.y};

   always_comb begin
      if (keep_ff && kx == '0) begin
         tie_less = lex_less(qx, qy, kx, ky);
      end else begin
         tie_less = lex_less(kx, ky, qx, qy);
      end
   end

   assign is_less = sgn.zero ? tie_less : !sgn.neg;
   assign do_pop  = keep_ff ? (!sgn.neg && !sgn.zero) : (!sgn.neg || sgn.zero);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:     if (req_acc && req_tlast) state_in = S_PIV_RD;
         S_PIV_RD:   state_in = S_PIV_CMP;
         S_PIV_CMP:  state_in = (i_nx == n_ff) ? S_SWP_RD : S_PIV_RD;
         S_SWP_RD:   state_in = S_SWP_W0;
         S_SWP_W0:   state_in = S_SWP_WB;
         S_SWP_WB:   state_in = (n_ff > CW'(2)) ? S_SRT_KEY : S_SCN_RD;
         S_SRT_KEY:  state_in = S_SRT_KWT;
         S_SRT_KWT:  state_in = S_SRT_RD;
         S_SRT_RD:   state_in = S_SRT_CMP;
         S_SRT_CMP:  state_in = S_SRT_WAIT;
         S_SRT_WAIT: begin
            if (sgn.done) begin
               state_in = (is_less && j_dec > CW'(1)) ? S_SRT_RD : S_SRT_PUT;
            end
         end
         S_SRT_PUT:  state_in = (i_nx < n_ff) ? S_SRT_KEY : S_SCN_RD;
         S_SCN_RD:   state_in = S_SCN_GET;
         S_SCN_GET:  state_in = (sz_ff > CW'(1)) ? S_SCN_CHK : S_SCN_PUSH;
         S_SCN_CHK:  state_in = S_SCN_WAIT;
         S_SCN_WAIT: begin
            if (sgn.done) begin
               state_in = (do_pop && sz_dec > CW'(1)) ? S_SCN_H0 : S_SCN_PUSH;
            end
         end
         S_SCN_H0:   state_in = S_SCN_CHK;
         S_SCN_PUSH: state_in = (i_nx < n_ff) ? S_SCN_RD : S_OUT_RD;
         S_OUT_RD:   state_in = S_OUT_GET;
         S_OUT_GET:  state_in = S_OUT_HOLD;
         S_OUT_HOLD: begin
            if (rsp_tready) state_in = rsp_last_ff ? S_LOAD : S_OUT_RD;
         end
         default:    state_in = S_LOAD;
      endcase
   end

   // Memory ports, sign unit operands and handshake outputs.
   always_comb begin
      st_we   = 1'b0;
      st_wa   = cnt_ff[AW-1:0];
      st_wd   = pt_type'(req_tdata);
      st_ra   = i_ff[AW-1:0];
      hs_we   = 1'b0;
      hs_wa   = sz_ff[AW-1:0];
      hs_wd   = p_ff;
      hs_ra   = i_ff[AW-1:0];
      x_start = 1'b0;
      x_ux    = {p_ff.x[31], p_ff.x} - {h1_ff.x[31], h1_ff.x};
      x_uy    = {p_ff.y[31], p_ff.y} - {h1_ff.y[31], h1_ff.y};
      x_wx    = {h1_ff.x[31], h1_ff.x} - {h0_ff.x[31], h0_ff.x};
      x_wy    = {h1_ff.y[31], h1_ff.y} - {h0_ff.y[31], h0_ff.y};
      unique case (state_ff)
         S_LOAD:     st_we = req_acc && (cnt_ff < CW'(MAX_POINTS));
         S_SWP_RD:   st_ra = '0;
         S_SWP_W0: begin
            st_we = 1'b1;
            st_wa = '0;
            st_wd = best_pt_ff;
         end
         S_SWP_WB: begin
            st_we = 1'b1;
            st_wa = best_ff[AW-1:0];
            st_wd = tmp_ff;
         end
         S_SRT_RD:   st_ra = j_dec[AW-1:0];
         S_SRT_CMP: begin
            x_start = 1'b1;
            x_ux    = kx;
            x_uy    = ky;
            x_wx    = {st_rd.x[31], st_rd.x} - {piv_ff.x[31], piv_ff.x};
            x_wy    = {st_rd.y[31], st_rd.y} - {piv_ff.y[31], piv_ff.y};
         end
         S_SRT_WAIT: begin
            st_we = sgn.done && is_less;
            st_wa = j_ff[AW-1:0];
            st_wd = q_ff;
         end
         S_SRT_PUT: begin
            st_we = 1'b1;
            st_wa = j_ff[AW-1:0];
            st_wd = key_ff;
         end
         S_SCN_CHK:  x_start = 1'b1;
         S_SCN_WAIT: hs_ra = sz_m3[AW-1:0];
         S_SCN_PUSH: hs_we = 1'b1;
         default: ;
      endcase
   end

   assign req_tready = (state_ff == S_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         keep_csr_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) keep_csr_ff <= csr_data;
         if (state_ff == S_LOAD && req_acc) begin
            if (req_tlast) begin
               cnt_ff <= '0;
            end else if (cnt_ff < CW'(MAX_POINTS)) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         if (state_ff == S_OUT_GET) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == S_OUT_HOLD && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers, updated per sequencer step.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_LOAD: begin
            if (req_acc && req_tlast) begin
               n_ff    <= (cnt_ff < CW'(MAX_POINTS)) ? cnt_ff + CW'(1) : cnt_ff;
               keep_ff <= keep_csr_ff;
               i_ff    <= '0;
               best_ff <= '0;
            end
         end
         S_PIV_CMP: begin
            if (i_ff == '0 || lex_less({st_rd.x[31], st_rd.x}, {st_rd.y[31], st_rd.y},
                                       {best_pt_ff.x[31], best_pt_ff.x},
                                       {best_pt_ff.y[31], best_pt_ff.y})) begin
               best_pt_ff <= st_rd;
               best_ff    <= i_ff;
            end
            i_ff <= i_nx;
         end
         S_SWP_W0: begin
            tmp_ff <= st_rd;
            piv_ff <= best_pt_ff;
         end
         S_SWP_WB: begin
            i_ff  <= (n_ff > CW'(2)) ? CW'(2) : '0;
            sz_ff <= '0;
         end
         S_SRT_KEY:  j_ff <= i_ff;
         S_SRT_KWT:  key_ff <= st_rd;
         S_SRT_CMP:  q_ff <= st_rd;
         S_SRT_WAIT: if (sgn.done && is_less) j_ff <= j_dec;
         S_SRT_PUT: begin
            i_ff  <= (i_nx < n_ff) ? i_nx : '0;
            sz_ff <= '0;
         end
         S_SCN_GET:  p_ff <= st_rd;
         S_SCN_WAIT: begin
            if (sgn.done && do_pop) begin
               sz_ff <= sz_dec;
               h1_ff <= h0_ff;
            end
         end
         S_SCN_H0:   h0_ff <= hs_rd;
         S_SCN_PUSH: begin
            h0_ff <= h1_ff;
            h1_ff <= p_ff;
            sz_ff <= sz_ff + CW'(1);
            i_ff  <= (i_nx < n_ff) ? i_nx : '0;
         end
         S_OUT_GET: begin
            rsp_data_ff <= hs_rd;
            rsp_last_ff <= (i_nx == sz_ff);
         end
         S_OUT_HOLD: if (rsp_tready) i_ff <= i_nx;
         default: ;
      endcase
   end

endmodule

[sv/cgs_checker.sv]
module cgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No point is taken while a hull vertex is waiting.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("point taken while a vertex is pending");

   // The final point starts the computation, which blocks new points.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready && !rsp_tvalid)
      else $error("input still open after final point");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind convex_hull_graham_scan cgs_checker u_cgs_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tlast(req_tlast),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
